### sv/chbf_pkg.sv
// Shared types and constants of the HTTP chunked body framer.
// Used by the front, the command queue and the back. No dependencies.
`default_nettype none
package chbf_pkg;

	localparam int LEN_W      = 32;
	localparam int NIB_N      = LEN_W / 4;
	localparam int NDIG_W     = 4;
	localparam int STEP_W     = 4;
	localparam int CMDQ_DEPTH = 2;

	localparam logic [1:0] ACT_OPEN  = 2'd0;
	localparam logic [1:0] ACT_DATA  = 2'd1;
	localparam logic [1:0] ACT_CLOSE = 2'd2;

	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	localparam logic [7:0] CH_CR   = 8'h0d;
	localparam logic [7:0] CH_LF   = 8'h0a;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_A    = 8'h61;

	typedef enum logic [1:0] {
		CMD_HEX,
		CMD_DATA,
		CMD_TERM
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [LEN_W-1:0]   len;
		logic [NDIG_W-1:0]  ndig;
		logic [7:0]         data;
		logic               crlf;
	} cmd_t;

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'd0, d};
		end else begin
			c = CH_A + {4'd0, d} - 8'd10;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### sv/http_chunked_body_framer_core.sv
// Top level of the HTTP chunked body framer.
// Instantiates chbf_front, chbf_cmdq and chbf_back; depends on chbf_pkg.
//
// Takes one word per cycle on push/full as long as the two-entry command
// queue has room, and delivers one link byte per cycle on empty/pop. A
// payload byte yields one link byte, the last byte of a chunk three
// (byte, CR, LF), a chunk open its hex digits plus CR and LF, the
// terminator five; words that produce nothing queue no command. The byte
// expander in the back end sets the sustained rate: full rises when it lags.
// Configuration writes take effect at once and belong to idle periods.
`default_nettype none
module http_chunked_body_framer_core import chbf_pkg::*; #(
	parameter int CHUNK_LEN_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [1:0]        action,
	input  wire logic [LEN_W-1:0]  chunk_length,
	input  wire logic [7:0]        data_byte,
	output logic                   empty,
	input  wire logic              pop,
	output logic [7:0]             out_byte,
	output logic                   framing,
	output logic                   last,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [63:0]       cfg_data
);

	logic cmd_valid;
	cmd_t cmd;
	logic q_valid;
	logic q_rd;
	cmd_t q_cmd;

	chbf_front #(
		.LEN_BITS(CHUNK_LEN_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.q_full       (full),
		.action       (action),
		.chunk_length (chunk_length),
		.data_byte    (data_byte),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd)
	);

	chbf_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_valid),
		.wr_cmd   (cmd),
		.full     (full),
		.rd_valid (q_valid),
		.rd_en    (q_rd),
		.rd_cmd   (q_cmd)
	);

	chbf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_rd     (q_rd),
		.pop      (pop),
		.empty    (empty),
		.out_byte (out_byte),
		.framing  (framing),
		.last     (last)
	);

endmodule
`default_nettype wire

### sv/chbf_front.sv
// Front end: configuration registers, body state and item classification.
// Turns each accepted word into at most one command. Depends on chbf_pkg.
`default_nettype none
module chbf_front import chbf_pkg::*; #(
	parameter int LEN_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic              q_full,
	input  wire logic [1:0]        action,
	input  wire logic [LEN_W-1:0]  chunk_length,
	input  wire logic [7:0]        data_byte,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [63:0]       cfg_data,
	output logic                   cmd_valid,
	output cmd_t                   cmd
);

	localparam int LW = (LEN_BITS < LEN_W) ? LEN_BITS : LEN_W;

	logic          mode_q;
	logic [63:0]   limit_q;
	logic          in_chunk_q;
	logic [LW-1:0] left_q;
	logic [63:0]   sent_q;
	logic          ended_q;

	logic          in_chunk_d;
	logic [LW-1:0] left_d;
	logic [63:0]   sent_d;
	logic          ended_d;
	logic          acc;
	logic          gen;
	logic [LW-1:0] len;
	logic [LEN_W-1:0] len_x;
	logic [NDIG_W-1:0] ndig;

	assign acc = push && !q_full;
	assign len = chunk_length[LW-1:0];
	assign len_x = LEN_W'(len);

	always_comb begin
		ndig = '0;
		for (int i = 0; i < NIB_N; i++) begin
			if (len_x[4*i +: 4] != 4'd0) begin
				ndig = NDIG_W'(i + 1);
			end
		end
	end

	always_comb begin
		gen        = 1'b0;
		cmd        = '0;
		cmd.kind   = CMD_DATA;
		cmd.data   = data_byte;
		in_chunk_d = in_chunk_q;
		left_d     = left_q;
		sent_d     = sent_q;
		ended_d    = ended_q;
		if (!ended_q) begin
			if (mode_q) begin
				case (action)
					ACT_OPEN: begin
						if (!in_chunk_q) begin
							gen = 1'b1;
							if (len == '0) begin
								cmd.kind = CMD_TERM;
								ended_d  = 1'b1;
							end else begin
								cmd.kind   = CMD_HEX;
								cmd.len    = len_x;
								cmd.ndig   = ndig;
								in_chunk_d = 1'b1;
								left_d     = len;
							end
						end
					end
					ACT_DATA: begin
						if (in_chunk_q) begin
							gen      = 1'b1;
							cmd.crlf = (left_q == LW'(1));
							left_d   = left_q - LW'(1);
							if (left_q == LW'(1)) begin
								in_chunk_d = 1'b0;
							end
						end
					end
					ACT_CLOSE: begin
						if (!in_chunk_q) begin
							gen      = 1'b1;
							cmd.kind = CMD_TERM;
							ended_d  = 1'b1;
						end
					end
					default: ;
				endcase
			end else if (action == ACT_DATA) begin
				if (limit_q == 64'd0) begin
					gen = 1'b1;
				end else if (sent_q < limit_q) begin
					gen    = 1'b1;
					sent_d = sent_q + 64'd1;
				end else begin
					ended_d = 1'b1;
				end
			end
		end
	end

	assign cmd_valid = acc && gen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			limit_q    <= '0;
			in_chunk_q <= 1'b0;
			left_q     <= '0;
			sent_q     <= '0;
			ended_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MODE:  mode_q  <= cfg_data[0];
					REG_LIMIT: limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (acc) begin
				in_chunk_q <= in_chunk_d;
				left_q     <= left_d;
				sent_q     <= sent_d;
				ended_q    <= ended_d;
			end
		end
	end

endmodule
`default_nettype wire

### sv/chbf_cmdq.sv
// Short command queue between front and back.
// Depth from chbf_pkg (power of two). Depends on chbf_pkg.
`default_nettype none
module chbf_cmdq import chbf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  cmd_t      wr_cmd,
	output logic      full,
	output logic      rd_valid,
	input  wire logic rd_en,
	output cmd_t      rd_cmd
);

	localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CW = $clog2(CMDQ_DEPTH + 1);

	cmd_t          mem_q [CMDQ_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(CMDQ_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_cmd   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + PW'(1);
			end
			if (rd_en) begin
				rptr_q <= rptr_q + PW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (!wr_en && rd_en) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

### sv/chbf_back.sv
// Back end: expands one command into link bytes, one per cycle while
// the output register is free or popped, into that register. Depends on chbf_pkg.
`default_nettype none
module chbf_back import chbf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	input  cmd_t      q_cmd,
	output logic      q_rd,
	input  wire logic pop,
	output logic      empty,
	output logic [7:0] out_byte,
	output logic      framing,
	output logic      last
);

	cmd_t              cur_q;
	logic              cur_valid_q;
	logic [STEP_W-1:0] step_q;
	logic              ovalid_q;

	logic              adv;
	logic              fin;
	logic              load_cur;
	logic [7:0]        nb;
	logic              nm;
	logic [STEP_W-1:0] rem;
	logic [3:0]        nib;

	assign rem = STEP_W'(cur_q.ndig) - step_q - STEP_W'(1);
	assign nib = cur_q.len[4*rem[2:0] +: 4];

	always_comb begin
		nb  = CH_LF;
		nm  = 1'b1;
		fin = 1'b0;
		case (cur_q.kind)
			CMD_HEX: begin
				fin = (step_q == STEP_W'(cur_q.ndig) + STEP_W'(1));
				if (step_q < STEP_W'(cur_q.ndig)) begin
					nb = hex_char(nib);
				end else if (step_q == STEP_W'(cur_q.ndig)) begin
					nb = CH_CR;
				end
			end
			CMD_DATA: begin
				fin = cur_q.crlf ? (step_q == STEP_W'(2)) : (step_q == '0);
				if (step_q == '0) begin
					nb = cur_q.data;
					nm = 1'b0;
				end else if (step_q == STEP_W'(1)) begin
					nb = CH_CR;
				end
			end
			CMD_TERM: begin
				fin = (step_q == STEP_W'(4));
				case (step_q)
					STEP_W'(0): nb = CH_ZERO;
					STEP_W'(1): nb = CH_CR;
					STEP_W'(3): nb = CH_CR;
					default:    nb = CH_LF;
				endcase
			end
			default: fin = 1'b1;
		endcase
	end

	assign adv      = cur_valid_q && (!ovalid_q || pop);
	assign load_cur = !cur_valid_q || (adv && fin);
	assign q_rd     = q_valid && load_cur;
	assign empty    = !ovalid_q;

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_q <= q_cmd;
		end
		if (adv) begin
			out_byte <= nb;
			framing  <= nm;
			last     <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q      <= '0;
			ovalid_q    <= 1'b0;
		end else begin
			if (q_rd) begin
				cur_valid_q <= 1'b1;
				step_q      <= '0;
			end else if (adv && fin) begin
				cur_valid_q <= 1'b0;
			end else if (adv) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (adv) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### sv/chbf_checker.sv
// Port-level checks for http_chunked_body_framer_core, with bind.
// Depends on chbf_pkg.
`default_nettype none
module chbf_checker import chbf_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [7:0]  out_byte,
	input wire logic        framing,
	input wire logic        last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last)))
		else $error("stalled word changed");

	a_cr_lf: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && framing && out_byte == CH_CR)
		|=> (!empty && framing && out_byte == CH_LF))
		else $error("CR not followed by LF");

	a_meta_end: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && framing && last) |-> (out_byte == CH_LF))
		else $error("framing does not end in LF");

	a_chunk_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !framing && !last)
		|=> (!empty && framing && out_byte == CH_CR))
		else $error("chunk tail missing CR");

endmodule

bind http_chunked_body_framer_core chbf_checker u_chk (.*);
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for http_chunked_body_framer_core (chunked and raw body framing).
// Depends on chbf_pkg and the core; predicts link words from its own model of the framer or from script rows.
`timescale 1ns / 100ps
module testbench;
	import chbf_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int PRED     = -1;
	localparam int SETTLE   = 16;
	localparam int WATCHDOG = 5000;
	localparam int NROWS    = 24;

	typedef struct packed {
		logic [7:0] value;
		logic       meta;
		logic       last;
	} link_byte_t;

	typedef struct packed {
		logic        is_reg;
		logic        ridx;
		logic [1:0]  act;
		logic [63:0] val;
		logic [7:0]  d;
		int          want_n;
		logic [7:0]  want_b;
		logic        want_m;
	} stim_row_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [1:0]        action = ACT_NONE;
	logic [LEN_W-1:0]  chunk_length = '0;
	logic [7:0]        data_byte = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic [7:0]        out_byte;
	logic              framing;
	logic              last;
	logic              cfg_we = 1'b0;
	logic              cfg_index = REG_MODE;
	logic [63:0]       cfg_data = '0;

	// framer model state
	bit          mode_chunked;
	logic [63:0] len_limit;
	bit          chunk_open;
	logic [31:0] chunk_left;
	logic [63:0] raw_count;
	bit          body_done;

	link_byte_t  frame_buf[$];
	link_byte_t  link_q[$];
	stim_row_t   script [0:NROWS-1];

	int errors = 0;
	int n_live = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	int run_left = 0;
	bit calm = 0;

	http_chunked_body_framer_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.chunk_length (chunk_length),
		.data_byte    (data_byte),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.framing      (framing),
		.last         (last),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void emit(input logic [7:0] v, input logic m);
		frame_buf.push_back(link_byte_t'{v, m, 1'b0});
	endfunction

	function automatic void emit_terminator();
		emit(CH_ZERO, 1'b1);
		emit(CH_CR, 1'b1);
		emit(CH_LF, 1'b1);
		emit(CH_CR, 1'b1);
		emit(CH_LF, 1'b1);
	endfunction

	function automatic void frame_word(input logic [1:0] act, input logic [31:0] len,
			input logic [7:0] d);
		int nd;
		int i;
		logic [31:0] t;
		logic [3:0] nib;
		link_byte_t tail;
		frame_buf.delete();
		if (body_done) return;
		if (mode_chunked) begin
			if (act == ACT_OPEN && !chunk_open) begin
				if (len == 0) begin
					emit_terminator();
					body_done = 1;
				end else begin
					nd = 0;
					t = len;
					while (t != 0) begin
						nd++;
						t = t >> 4;
					end
					for (i = nd - 1; i >= 0; i--) begin
						nib = len[4*i +: 4];
						if (nib < 4'd10) emit(CH_ZERO + {4'd0, nib}, 1'b1);
						else emit(CH_A + {4'd0, nib} - 8'd10, 1'b1);
					end
					emit(CH_CR, 1'b1);
					emit(CH_LF, 1'b1);
					chunk_open = 1;
					chunk_left = len;
				end
			end else if (act == ACT_DATA && chunk_open) begin
				emit(d, 1'b0);
				chunk_left = chunk_left - 32'd1;
				if (chunk_left == 0) begin
					emit(CH_CR, 1'b1);
					emit(CH_LF, 1'b1);
					chunk_open = 0;
				end
			end else if (act == ACT_CLOSE && !chunk_open) begin
				emit_terminator();
				body_done = 1;
			end
		end else if (act == ACT_DATA) begin
			if (len_limit == 0) begin
				emit(d, 1'b0);
			end else if (raw_count < len_limit) begin
				emit(d, 1'b0);
				raw_count = raw_count + 64'd1;
			end else begin
				body_done = 1;
			end
		end
		if (frame_buf.size() > 0) begin
			tail = frame_buf.pop_back();
			tail.last = 1'b1;
			frame_buf.push_back(tail);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	task automatic put_word(input logic [1:0] act, input logic [31:0] len,
			input logic [7:0] d, input int want_n, input logic [7:0] want_b,
			input logic want_m);
		int gap;
		int i;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk) push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		action <= act;
		chunk_length <= len;
		data_byte <= d;
		do @(posedge clk); while (full);
		frame_word(act, len, d);
		if (frame_buf.size() > 0) n_live++;
		if (want_n == PRED) begin
			for (i = 0; i < frame_buf.size(); i++) link_q.push_back(frame_buf[i]);
		end else if (want_n == 1) begin
			link_q.push_back(link_byte_t'{want_b, want_m, 1'b1});
		end
	endtask

	task automatic drain();
		@(negedge clk) push <= 1'b0;
		while (link_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_reg(input logic idx, input logic [63:0] v);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk) cfg_we <= 1'b0;
		if (idx == REG_MODE) mode_chunked = v[0];
		else len_limit = v;
	endtask

	task automatic put_noise(input bit in_body);
		int r;
		r = $urandom_range(0, 2);
		if (r == 0) put_word(ACT_NONE, $urandom, 8'($urandom), PRED, 8'h00, 1'b0);
		else if (in_body && r == 1)
			put_word(ACT_OPEN, $urandom, 8'($urandom), PRED, 8'h00, 1'b0);
		else if (in_body) put_word(ACT_CLOSE, $urandom, 8'($urandom), PRED, 8'h00, 1'b0);
		else put_word(ACT_DATA, $urandom, 8'($urandom), PRED, 8'h00, 1'b0);
	endtask

	// well-formed chunks with random content, plus harmless noise
	task automatic chunk_burst(input int target);
		int start;
		int r;
		int len;
		int j;
		start = n_live;
		while (n_live - start < target) begin
			if ($urandom_range(0, 31) == 0) calm = !calm;
			r = $urandom_range(0, 99);
			if (r < 12) begin
				put_noise(0);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) len = $urandom_range(1, 8);
				else if (r < 95) len = $urandom_range(9, 40);
				else len = $urandom_range(41, 120);
				put_word(ACT_OPEN, len, 8'($urandom), PRED, 8'h00, 1'b0);
				for (j = 0; j < len; j++) begin
					if ($urandom_range(0, 99) < 8) put_noise(1);
					put_word(ACT_DATA, $urandom, 8'($urandom), PRED, 8'h00, 1'b0);
				end
			end
		end
	endtask

	// raw body; with an exact limit the last byte lands right on it
	task automatic raw_burst(input int nbytes, input bit exact);
		int j;
		if (exact) set_reg(REG_LIMIT, raw_count + nbytes);
		else if ($urandom_range(0, 1)) set_reg(REG_LIMIT, 64'd0);
		else set_reg(REG_LIMIT, '1);
		for (j = 0; j < nbytes; j++) begin
			if ($urandom_range(0, 31) == 0) calm = !calm;
			if ($urandom_range(0, 99) < 10) put_noise(1);
			put_word(ACT_DATA, $urandom, 8'($urandom), PRED, 8'h00, 1'b0);
		end
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			pop <= 1'b0;
			stall_left--;
		end else begin
			pop <= 1'b1;
			if (run_left > 0) begin
				run_left--;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: stall_left = $urandom_range(0, 3);
					6, 7, 8: stall_left = $urandom_range(4, 12);
					default: stall_left = $urandom_range(20, 60);
				endcase
				if ($urandom_range(0, 7) == 0) run_left = $urandom_range(30, 80);
				else run_left = $urandom_range(0, 4);
			end
		end
	end

	always @(posedge clk) begin : check_link
		link_byte_t want;
		if (arst_n && pop && !empty) begin
			if (link_q.size() == 0) begin
				$error("unexpected word: out_byte %h framing %b last %b",
					out_byte, framing, last);
				errors++;
			end else begin
				want = link_q.pop_front();
				if (out_byte !== want.value) begin
					$error("out_byte: expected %h, got %h", want.value, out_byte);
					errors++;
				end
				if (framing !== want.meta) begin
					$error("framing: expected %b, got %b", want.meta, framing);
					errors++;
				end
				if (last !== want.last) begin
					$error("last: expected %b, got %b", want.last, last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		script = '{
			'{1'b0, REG_MODE,  ACT_DATA,  64'd0,         8'h00, 1,    8'h00, 1'b0},
			'{1'b0, REG_MODE,  ACT_DATA,  64'd0,         8'hff, 1,    8'hff, 1'b0},
			'{1'b0, REG_MODE,  ACT_OPEN,  64'd5,         8'h00, 0,    8'h00, 1'b0},
			'{1'b0, REG_MODE,  ACT_CLOSE, 64'd0,         8'h00, 0,    8'h00, 1'b0},
			'{1'b0, REG_MODE,  ACT_NONE,  64'd0,         8'h00, 0,    8'h00, 1'b0},
			'{1'b1, REG_LIMIT, ACT_OPEN,  64'd2,         8'h00, PRED, 8'h00, 1'b0},
			'{1'b0, REG_MODE,  ACT_DATA,  64'd0,         8'h11, PRED, 8'h00, 1'b0},
			'{1'b0, REG_MODE,  ACT_DATA,  64'd0,         8'h22, PRED, 8'h00, 1'b0},
			'{1'b1, REG_LIMIT, ACT_OPEN,  '1,            8'h00, PRED, 8'h00, 1'b0},
			'{1'b0, REG_MODE,  ACT_DATA,  64'd0,         8'h33, PRED, 8'h00, 1'b0},
			'{1'b1, REG_MODE,  ACT_OPEN,  64'd1,         8'h00, PRED, 8'h00, 1'b0},
			'{1'b0, REG_MODE,  ACT_DATA,  64'd0,         8'h44, 0,    8'h00, 1'b0},
			'{1'b0, REG_MODE,  ACT_NONE,  64'd0,         8'h00, 0,    8'h00, 1'b0},
			'{1'b0, REG_MODE,  ACT_OPEN,  64'd1,         8'h00, PRED, 8'h00, 1'b0},
			'{1'b0, REG_MODE,  ACT_OPEN,  64'hffffffff,  8'h00, 0,    8'h00, 1'b0},
			'{1'b0, REG_MODE,  ACT_CLOSE, 64'd0,         8'h00, 0,    8'h00, 1'b0},
			'{1'b0, REG_MODE,  ACT_DATA,  64'd0,         8'h00, PRED, 8'h00, 1'b0},
			'{1'b0, REG_MODE,  ACT_OPEN,  64'd3,         8'h00, PRED, 8'h00, 1'b0},
			'{1'b0, REG_MODE,  ACT_DATA,  64'd0,         8'hff, PRED, 8'h00, 1'b0},
			'{1'b0, REG_MODE,  ACT_DATA,  64'd0,         8'h80, PRED, 8'h00, 1'b0},
			'{1'b0, REG_MODE,  ACT_DATA,  64'd0,         8'h01, PRED, 8'h00, 1'b0},
			'{1'b0, REG_MODE,  ACT_OPEN,  64'd1,         8'h00, PRED, 8'h00, 1'b0},
			'{1'b0, REG_MODE,  ACT_OPEN,  64'd0,         8'h00, 0,    8'h00, 1'b0},
			'{1'b0, REG_MODE,  ACT_DATA,  64'd0,         8'h7e, PRED, 8'h00, 1'b0}
		};
		mode_chunked = 0;
		len_limit = '0;
		chunk_open = 0;
		chunk_left = '0;
		raw_count = '0;
		body_done = 0;

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].is_reg) set_reg(script[i].ridx, script[i].val);
			else put_word(script[i].act, script[i].val[31:0], script[i].d,
				script[i].want_n, script[i].want_b, script[i].want_m);
		end

		chunk_burst(130);
		set_reg(REG_MODE, 64'd0);
		raw_burst(45, 1);
		raw_burst(45, 0);
		set_reg(REG_MODE, 64'd1);
		set_reg(REG_LIMIT, {$urandom, $urandom});
		chunk_burst(130);

		// end of body, either spelling, then nothing may come out
		if ($urandom_range(0, 1))
			put_word(ACT_CLOSE, $urandom, 8'($urandom), PRED, 8'h00, 1'b0);
		else put_word(ACT_OPEN, 32'd0, 8'($urandom), PRED, 8'h00, 1'b0);
		put_word(ACT_OPEN, 32'd7, 8'($urandom), PRED, 8'h00, 1'b0);
		put_word(ACT_DATA, $urandom, 8'($urandom), PRED, 8'h00, 1'b0);
		put_word(ACT_CLOSE, $urandom, 8'($urandom), PRED, 8'h00, 1'b0);
		put_word(ACT_NONE, $urandom, 8'($urandom), PRED, 8'h00, 1'b0);
		set_reg(REG_MODE, 64'd0);
		set_reg(REG_LIMIT, 64'd0);
		put_word(ACT_DATA, $urandom, 8'($urandom), PRED, 8'h00, 1'b0);
		put_word(ACT_DATA, $urandom, 8'($urandom), PRED, 8'h00, 1'b0);

		drain();
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### sim.f
sv/chbf_pkg.sv
sv/chbf_front.sv
sv/chbf_cmdq.sv
sv/chbf_back.sv
sv/http_chunked_body_framer_core.sv
sv/chbf_checker.sv
tb/sv/testbench.sv
